[rtl/core/i2c_sensor_command_master_assert.svh]
// ----------------------------------------------------------------------------
// I2C sensor command master assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef I2C_SENSOR_COMMAND_MASTER_ASSERT_SVH
`define I2C_SENSOR_COMMAND_MASTER_ASSERT_SVH

// same-cycle implication
`define I2CSCM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define I2CSCM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/i2cscm_pkg.sv]
// ----------------------------------------------------------------------------
// i2cscm_pkg
// Types and constants shared by the I2C sensor command master.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cscm_pkg;

  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_SCL    = 2'd1;
  localparam logic [1:0] ERR_NOACK  = 2'd2;
  localparam logic [1:0] ERR_BUSY   = 2'd3;

  localparam logic [1:0] CFG_SLAVE_ADDR   = 2'd0;
  localparam logic [1:0] CFG_EXTRA_CMD    = 2'd1;
  localparam logic [1:0] CFG_EXTRA_VALUE  = 2'd2;
  localparam logic [1:0] CFG_TWO_BYTE_CMD = 2'd3;

  localparam logic [6:0] SLAVE_ADDR_RST   = 7'd72;
  localparam logic [7:0] EXTRA_CMD_RST    = 8'hAC;
  localparam logic [7:0] EXTRA_VALUE_RST  = 8'h03;
  localparam logic [7:0] TWO_BYTE_CMD_RST = 8'hAA;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] command_code;
    logic       sda_in;
    logic       scl_in;
  } req_word_t;

  typedef struct packed {
    logic       sda_release;
    logic       scl_release;
    logic       busy_res;
    logic       done_res;
    logic [1:0] error_code;
    logic [7:0] read_data;
  } res_word_t;

  typedef struct packed {
    logic [6:0] slave_address;
    logic [7:0] extra_byte_command;
    logic [7:0] extra_byte_value;
    logic [7:0] two_byte_read_command;
  } cfg_t;

endpackage

`default_nettype wire

[rtl/core/i2cscm_cfg.sv]
// ----------------------------------------------------------------------------
// i2cscm_cfg
// Configuration registers, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cscm_cfg
  import i2cscm_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_addr_i,
  input  wire logic [7:0] cfg_wdata_i,
  output cfg_t            cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.slave_address         <= SLAVE_ADDR_RST;
      cfg_q.extra_byte_command    <= EXTRA_CMD_RST;
      cfg_q.extra_byte_value      <= EXTRA_VALUE_RST;
      cfg_q.two_byte_read_command <= TWO_BYTE_CMD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_SLAVE_ADDR:   cfg_q.slave_address         <= cfg_wdata_i[6:0];
        CFG_EXTRA_CMD:    cfg_q.extra_byte_command    <= cfg_wdata_i;
        CFG_EXTRA_VALUE:  cfg_q.extra_byte_value      <= cfg_wdata_i;
        CFG_TWO_BYTE_CMD: cfg_q.two_byte_read_command <= cfg_wdata_i;
        default:          cfg_q <= cfg_q;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[rtl/core/i2cscm_step.sv]
// ----------------------------------------------------------------------------
// i2cscm_step
// Bus sequencer: one bus step per accepted tick word, state held in registers.
// ----------------------------------------------------------------------------
`default_nettype none

`include "i2c_sensor_command_master_assert.svh"

module i2cscm_step
  import i2cscm_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  accept_i,
  input  req_word_t  req_i,
  input  cfg_t       cfg_i,
  output res_word_t  res_o
);

  typedef enum logic [4:0] {
    PH_IDLE, PH_S_SDAUP, PH_S_SCLUP, PH_S_SDADN, PH_S_SCLDN, PH_S_CHECK,
    PH_B_DATA, PH_B_SCLUP, PH_B_SCLDN, PH_A_SDAUP, PH_A_SCLUP, PH_A_SCLDN,
    PH_RS_SDAUP, PH_RS_SCLUP, PH_RS_SDADN, PH_RS_SCLDN,
    PH_R_SDAUP, PH_R_SCLUP, PH_R_SCLDN,
    PH_M_SDADN, PH_M_SCLUP, PH_M_SCLDN, PH_M_SDAUP,
    PH_D_SCLUP, PH_D_SCLDN,
    PH_N_SDAUP, PH_N_SCLUP, PH_N_SCLDN,
    PH_P_SDADN, PH_P_SCLUP, PH_P_SDAUP
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [3:0] bit_count_q, bit_count_d;
  logic [7:0] tx_shift_q, tx_shift_d;
  logic [7:0] rx_shift_q, rx_shift_d;
  logic [7:0] latched_cmd_q, latched_cmd_d;
  logic       is_read_q, is_read_d;
  logic       sda_level_q, sda_level_d;
  logic       scl_level_q, scl_level_d;
  logic [1:0] byte_stage_q, byte_stage_d;
  logic [7:0] last_read_q, last_read_d;
  logic [1:0] err;
  logic       done;
  logic [3:0] bit_count_inc;

  assign bit_count_inc = bit_count_q + 4'd1;

  always_comb begin
    phase_d       = phase_q;
    bit_count_d   = bit_count_q;
    tx_shift_d    = tx_shift_q;
    rx_shift_d    = rx_shift_q;
    latched_cmd_d = latched_cmd_q;
    is_read_d     = is_read_q;
    sda_level_d   = sda_level_q;
    scl_level_d   = scl_level_q;
    byte_stage_d  = byte_stage_q;
    last_read_d   = last_read_q;
    err           = ERR_NONE;
    done          = 1'b0;

    if (accept_i) begin
      priority if (req_i.req_type == REQ_WRITE || req_i.req_type == REQ_READ) begin
        if (phase_q != PH_IDLE) begin
          err = ERR_BUSY;
        end else begin
          latched_cmd_d = req_i.command_code;
          is_read_d     = (req_i.req_type == REQ_READ);
          bit_count_d   = 4'd0;
          phase_d       = PH_S_SDAUP;
        end
      end else if (req_i.req_type == REQ_TICK && phase_q != PH_IDLE) begin
        unique case (phase_q)
          PH_S_SDAUP: begin sda_level_d = 1'b1; phase_d = PH_S_SCLUP; end
          PH_S_SCLUP: begin scl_level_d = 1'b1; phase_d = PH_S_SDADN; end
          PH_S_SDADN: begin sda_level_d = 1'b0; phase_d = PH_S_SCLDN; end
          PH_S_SCLDN: begin
            scl_level_d  = 1'b0;
            tx_shift_d   = {cfg_i.slave_address, 1'b0};
            byte_stage_d = 2'd0;
            bit_count_d  = 4'd0;
            phase_d      = PH_S_CHECK;
          end
          PH_S_CHECK: begin
            if (req_i.scl_in) begin
              err     = ERR_SCL;
              done    = 1'b1;
              phase_d = PH_IDLE;
            end else begin
              sda_level_d = tx_shift_q[7];
              phase_d     = PH_B_SCLUP;
            end
          end
          PH_B_DATA: begin
            sda_level_d = tx_shift_q[7];
            phase_d     = PH_B_SCLUP;
          end
          PH_B_SCLUP: begin scl_level_d = 1'b1; phase_d = PH_B_SCLDN; end
          PH_B_SCLDN: begin
            scl_level_d = 1'b0;
            tx_shift_d  = {tx_shift_q[6:0], 1'b0};
            if (bit_count_inc[3]) begin
              bit_count_d = 4'd0;
              phase_d     = PH_A_SDAUP;
            end else begin
              bit_count_d = bit_count_inc;
              phase_d     = PH_B_DATA;
            end
          end
          PH_A_SDAUP: begin sda_level_d = 1'b1; phase_d = PH_A_SCLUP; end
          PH_A_SCLUP: begin scl_level_d = 1'b1; phase_d = PH_A_SCLDN; end
          PH_A_SCLDN: begin
            scl_level_d = 1'b0;
            if (req_i.sda_in) begin
              err     = ERR_NOACK;
              done    = 1'b1;
              phase_d = PH_IDLE;
            end else begin
              unique case (byte_stage_q)
                2'd0: begin
                  tx_shift_d   = latched_cmd_q;
                  byte_stage_d = 2'd1;
                  bit_count_d  = 4'd0;
                  phase_d      = PH_B_DATA;
                end
                2'd1: begin
                  priority if (is_read_q) begin
                    phase_d = PH_RS_SDAUP;
                  end else if (latched_cmd_q == cfg_i.extra_byte_command) begin
                    tx_shift_d   = cfg_i.extra_byte_value;
                    byte_stage_d = 2'd2;
                    bit_count_d  = 4'd0;
                    phase_d      = PH_B_DATA;
                  end else begin
                    phase_d = PH_P_SDADN;
                  end
                end
                2'd2: phase_d = PH_P_SDADN;
                default: phase_d = PH_R_SDAUP;
              endcase
            end
          end
          PH_RS_SDAUP: begin sda_level_d = 1'b1; phase_d = PH_RS_SCLUP; end
          PH_RS_SCLUP: begin scl_level_d = 1'b1; phase_d = PH_RS_SDADN; end
          PH_RS_SDADN: begin sda_level_d = 1'b0; phase_d = PH_RS_SCLDN; end
          PH_RS_SCLDN: begin
            scl_level_d  = 1'b0;
            tx_shift_d   = {cfg_i.slave_address, 1'b1};
            byte_stage_d = 2'd3;
            bit_count_d  = 4'd0;
            phase_d      = PH_B_DATA;
          end
          PH_R_SDAUP: begin
            sda_level_d = 1'b1;
            rx_shift_d  = 8'd0;
            bit_count_d = 4'd0;
            phase_d     = PH_R_SCLUP;
          end
          PH_R_SCLUP: begin scl_level_d = 1'b1; phase_d = PH_R_SCLDN; end
          PH_R_SCLDN: begin
            rx_shift_d  = {rx_shift_q[6:0], req_i.sda_in};
            scl_level_d = 1'b0;
            if (bit_count_inc[3]) begin
              bit_count_d = 4'd0;
              phase_d     = (latched_cmd_q == cfg_i.two_byte_read_command) ?
                            PH_M_SDADN : PH_N_SDAUP;
            end else begin
              bit_count_d = bit_count_inc;
              phase_d     = PH_R_SCLUP;
            end
          end
          PH_M_SDADN: begin sda_level_d = 1'b0; phase_d = PH_M_SCLUP; end
          PH_M_SCLUP: begin scl_level_d = 1'b1; phase_d = PH_M_SCLDN; end
          PH_M_SCLDN: begin scl_level_d = 1'b0; phase_d = PH_M_SDAUP; end
          PH_M_SDAUP: begin
            sda_level_d = 1'b1;
            bit_count_d = 4'd0;
            phase_d     = PH_D_SCLUP;
          end
          PH_D_SCLUP: begin scl_level_d = 1'b1; phase_d = PH_D_SCLDN; end
          PH_D_SCLDN: begin
            scl_level_d = 1'b0;
            if (bit_count_inc[3]) begin
              bit_count_d = 4'd0;
              phase_d     = PH_N_SDAUP;
            end else begin
              bit_count_d = bit_count_inc;
              phase_d     = PH_D_SCLUP;
            end
          end
          PH_N_SDAUP: begin sda_level_d = 1'b1; phase_d = PH_N_SCLUP; end
          PH_N_SCLUP: begin scl_level_d = 1'b1; phase_d = PH_N_SCLDN; end
          PH_N_SCLDN: begin scl_level_d = 1'b0; phase_d = PH_P_SDADN; end
          PH_P_SDADN: begin sda_level_d = 1'b0; phase_d = PH_P_SCLUP; end
          PH_P_SCLUP: begin scl_level_d = 1'b1; phase_d = PH_P_SDAUP; end
          PH_P_SDAUP: begin
            sda_level_d = 1'b1;
            if (is_read_q) begin
              last_read_d = rx_shift_q;
            end
            done    = 1'b1;
            phase_d = PH_IDLE;
          end
          default: phase_d = PH_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      bit_count_q   <= 4'd0;
      tx_shift_q    <= 8'd0;
      rx_shift_q    <= 8'd0;
      latched_cmd_q <= 8'd0;
      is_read_q     <= 1'b0;
      sda_level_q   <= 1'b1;
      scl_level_q   <= 1'b1;
      byte_stage_q  <= 2'd0;
      last_read_q   <= 8'd0;
    end else begin
      phase_q       <= phase_d;
      bit_count_q   <= bit_count_d;
      tx_shift_q    <= tx_shift_d;
      rx_shift_q    <= rx_shift_d;
      latched_cmd_q <= latched_cmd_d;
      is_read_q     <= is_read_d;
      sda_level_q   <= sda_level_d;
      scl_level_q   <= scl_level_d;
      byte_stage_q  <= byte_stage_d;
      last_read_q   <= last_read_d;
    end
  end

  always_comb begin
    res_o.sda_release = sda_level_d;
    res_o.scl_release = scl_level_d;
    res_o.busy_res    = (phase_d != PH_IDLE);
    res_o.done_res    = done;
    res_o.error_code  = err;
    res_o.read_data   = last_read_d;
  end

  `I2CSCM_ASSERT_IMP(a_done_ends_job, accept_i && done, phase_d == PH_IDLE, "done without idle")
  `I2CSCM_ASSERT_IMP(a_bus_err_with_done, accept_i && (err == ERR_SCL || err == ERR_NOACK), done, "bus error without done")
  `I2CSCM_ASSERT_IMP(a_bit_count_range, 1'b1, bit_count_q <= 4'd8, "bit count out of range")
  `I2CSCM_ASSERT_NXT(a_hold_when_idle, !accept_i, $stable(phase_q) && $stable(last_read_q), "state moved without word")

endmodule

`default_nettype wire

[rtl/core/i2cscm_skid.sv]
// ----------------------------------------------------------------------------
// i2cscm_skid
// Result register with a skid stage, so one more input word is taken while the output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

`include "i2c_sensor_command_master_assert.svh"

module i2cscm_skid
  import i2cscm_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_stall_o,
  output logic       accept_o,
  input  res_word_t  res_i,
  output logic       out_valid_o,
  input  wire logic  out_stall_i,
  output res_word_t  out_data_o
);

  logic      main_valid_q, main_valid_d;
  logic      skid_valid_q, skid_valid_d;
  res_word_t main_data_q, main_data_d;
  res_word_t skid_data_q, skid_data_d;
  logic      pop;

  assign in_stall_o = skid_valid_q;
  assign accept_o   = in_valid_i && !skid_valid_q;
  assign pop        = main_valid_q && !out_stall_i;

  always_comb begin
    main_valid_d = main_valid_q;
    skid_valid_d = skid_valid_q;
    main_data_d  = main_data_q;
    skid_data_d  = skid_data_q;
    priority if (pop) begin
      if (skid_valid_q) begin
        main_data_d  = skid_data_q;
        skid_valid_d = 1'b0;
      end else if (accept_o) begin
        main_data_d = res_i;
      end else begin
        main_valid_d = 1'b0;
      end
    end else if (!main_valid_q) begin
      if (accept_o) begin
        main_data_d  = res_i;
        main_valid_d = 1'b1;
      end
    end else if (accept_o) begin
      skid_data_d  = res_i;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      main_valid_q <= main_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    main_data_q <= main_data_d;
    skid_data_q <= skid_data_d;
  end

  assign out_valid_o = main_valid_q;
  assign out_data_o  = main_data_q;

  `I2CSCM_ASSERT_IMP(a_skid_needs_main, skid_valid_q, main_valid_q, "skid full with empty output")
  `I2CSCM_ASSERT_NXT(a_skid_refills_main, skid_valid_q && !out_stall_i, main_valid_q, "skid word lost")
  `I2CSCM_ASSERT_NXT(a_stalled_word_to_skid, accept_o && main_valid_q && out_stall_i, skid_valid_q, "accepted word dropped")

endmodule

`default_nettype wire

[rtl/core/i2c_sensor_command_master.sv]
// ----------------------------------------------------------------------------
// i2c_sensor_command_master
// Open-drain I2C master running one sensor command transaction per request.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one request
//   word: a bus step tick, or a write or read start with its command code,
//   plus the sampled SDA and SCL levels. Each accepted word yields exactly one
//   result word on the output channel (out_valid_o / out_stall_i /
//   out_data_o) with the line releases, busy, done, error code and read byte.
//   An accepted word's result is registered in the result register, or in the
//   skid stage while the output stalls. Throughput is one word per cycle
//   while in_stall_o is low; the sequencer steps at most once per accepted
//   word and the result register with its skid stage takes the next word
//   while a result waits. When the receiver stalls, one more word is taken
//   into the skid stage and then in_stall_o rises until the output drains.
//   Reset puts the bus idle with both lines released, clears the read byte
//   and loads the configuration defaults (address 0x48, extra command 0xAC,
//   extra value 0x03, two-byte read command 0xAA).
//   Configuration is written through cfg_we_i / cfg_addr_i / cfg_wdata_i.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_sensor_command_master
  import i2cscm_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_addr_i,
  input  wire logic [7:0] cfg_wdata_i,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  req_word_t       in_data_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output res_word_t       out_data_o
);

  cfg_t      cfg;
  res_word_t res;
  logic      accept;

  i2cscm_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  i2cscm_step u_step (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .req_i   (in_data_i),
    .cfg_i   (cfg),
    .res_o   (res)
  );

  i2cscm_skid u_skid (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .accept_o   (accept),
    .res_i      (res),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire
